// ----- design/windowed_latency_path_failover_assert.svh -----
// assertion macros for the windowed latency path failover block
// expect clk_i and rst_ni in the scope of the module that uses them
`ifndef WINDOWED_LATENCY_PATH_FAILOVER_ASSERT_SVH
`define WINDOWED_LATENCY_PATH_FAILOVER_ASSERT_SVH

// same-cycle implication
`define WLPF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wlpf assertion failed");

// next-cycle implication
`define WLPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wlpf assertion failed");

`endif

// ----- design/wlpf_pkg.sv -----
// shared types and constants for the windowed latency path failover block
// no dependencies
package wlpf_pkg;

  localparam int unsigned FUNC_W  = 1;
  localparam int unsigned IFACE_W = 3;
  localparam int unsigned LAT_W   = 16;
  localparam int unsigned MEAN_W  = 24;
  localparam int unsigned SWCNT_W = 32;
  localparam int unsigned FRAC_W  = 8;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned NUM_IFACES_DEF = 8;
  localparam int unsigned WINDOW_LEN_DEF = 100;

  localparam logic [LAT_W-1:0]   THRESHOLD_RST = LAT_W'(30);
  localparam logic [IFACE_W-1:0] PRIMARY_RST   = IFACE_W'(1);
  localparam logic [IFACE_W-1:0] SECONDARY_RST = IFACE_W'(2);

  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_PRIMARY   = 2'd1,
    CFG_SECONDARY = 2'd2
  } wlpf_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIV,
    ST_EVAL_P,
    ST_EVAL_S,
    ST_DECIDE,
    ST_DONE
  } wlpf_state_e;

endpackage

// ----- design/wlpf_if.sv -----
// valid/ready channel interfaces for sample/tick items and results
// depends on wlpf_pkg
interface wlpf_in_if;
  import wlpf_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [IFACE_W-1:0] iface;
  logic [LAT_W-1:0]   latency_ms;

  modport source (output valid, func, iface, latency_ms, input ready);
  modport sink   (input valid, func, iface, latency_ms, output ready);
endinterface

interface wlpf_out_if;
  import wlpf_pkg::*;

  logic               valid;
  logic               ready;
  logic [IFACE_W-1:0] current_path;
  logic               switched;
  logic [SWCNT_W-1:0] switch_count;
  logic [MEAN_W-1:0]  mean_latency_q8;

  modport source (output valid, current_path, switched, switch_count, mean_latency_q8,
                  input ready);
  modport sink   (input valid, current_path, switched, switch_count, mean_latency_q8,
                  output ready);
endinterface

// ----- design/wlpf_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module wlpf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/wlpf_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
// no dependencies
module wlpf_div #(
  parameter int unsigned DVD_W = 31,
  parameter int unsigned DVS_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    rem_sub;
  logic              qbit;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    qbit    = (rem_sh >= {1'b0, dvs_q});

    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;

    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(DVD_W - 1);
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = qbit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      dvd_d = {dvd_q[DVD_W-2:0], qbit};
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ----- design/windowed_latency_path_failover.sv -----
// top level of the windowed latency path failover block
// depends on wlpf_pkg, wlpf_if, wlpf_ram, wlpf_div and the assertion header
//
//  channel  dir  handshake      payload
//  in_i     in   valid/ready    func, iface, latency_ms
//  out_o    out  valid/ready    current_path, switched, switch_count, mean_latency_q8
//  cfg      in   cfg_we_i       cfg_idx_i, cfg_wdata_i
//
// a sample transaction runs from accept through ring read, window update and the serial
//   mean divide to result load and back to idle, ready for the next accept
// a tick transaction steps through two mean reads, decision, result load and idle
// one item at a time: in_i.ready is high only while the sequencer is idle
// a finished result waits in the output register; the next item is accepted meanwhile
// reset clears all window state at once; sample storage needs no clearing pass
`include "windowed_latency_path_failover_assert.svh"

module windowed_latency_path_failover #(
  parameter int unsigned NUM_IFACES = wlpf_pkg::NUM_IFACES_DEF,
  parameter int unsigned WINDOW_LEN = wlpf_pkg::WINDOW_LEN_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  wlpf_in_if.sink                          in_i,
  wlpf_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [wlpf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [wlpf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import wlpf_pkg::*;

  localparam int unsigned IFC_W   = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;
  localparam int unsigned POS_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned CNT_W   = $clog2(WINDOW_LEN + 1);
  localparam int unsigned SUM_W   = LAT_W + CNT_W;
  localparam int unsigned DVD_W   = SUM_W + FRAC_W;
  localparam int unsigned RAM_DEP = NUM_IFACES << POS_W;
  localparam int unsigned RAM_AW  = $clog2(RAM_DEP);
  localparam int unsigned CMP_W   = MEAN_W + 4;

  wlpf_state_e state_q, state_d;

  logic [FUNC_W-1:0]  func_q, func_d;
  logic [IFACE_W-1:0] ifc_q, ifc_d;
  logic [LAT_W-1:0]   lat_q, lat_d;

  logic [SUM_W-1:0]  sum_q  [NUM_IFACES];
  logic [SUM_W-1:0]  sum_d  [NUM_IFACES];
  logic [CNT_W-1:0]  cnt_q  [NUM_IFACES];
  logic [CNT_W-1:0]  cnt_d  [NUM_IFACES];
  logic [POS_W-1:0]  slot_q [NUM_IFACES];
  logic [POS_W-1:0]  slot_d [NUM_IFACES];
  logic [MEAN_W-1:0] mean_q [NUM_IFACES];
  logic [MEAN_W-1:0] mean_d [NUM_IFACES];

  logic               on_sec_q, on_sec_d;
  logic [SWCNT_W-1:0] sw_total_q, sw_total_d;
  logic [LAT_W-1:0]   thr_q, thr_d;
  logic [IFACE_W-1:0] pri_q, pri_d;
  logic [IFACE_W-1:0] sec_q, sec_d;

  logic [MEAN_W-1:0] p_q, p_d;
  logic [MEAN_W-1:0] s_q, s_d;
  logic [MEAN_W-1:0] res_mean_q, res_mean_d;
  logic              res_sw_q, res_sw_d;

  logic               out_valid_q, out_valid_d;
  logic [IFACE_W-1:0] out_path_q, out_path_d;
  logic               out_sw_q, out_sw_d;
  logic [SWCNT_W-1:0] out_cnt_q, out_cnt_d;
  logic [MEAN_W-1:0]  out_mean_q, out_mean_d;

  logic               accept;
  logic               res_load;
  logic [IFC_W-1:0]   ifc_idx;
  logic [IFACE_W-1:0] mean_sel;
  logic [IFC_W-1:0]   mean_idx;
  logic               mean_ok;
  logic [MEAN_W-1:0]  mean_rd;
  logic               full;
  logic [SUM_W-1:0]   new_sum;
  logic [CNT_W-1:0]   new_cnt;
  logic [MEAN_W-1:0]  thr_q8;
  logic               go;

  logic              ram_we;
  logic              ram_re;
  logic [RAM_AW-1:0] ram_addr;
  logic [LAT_W-1:0]  ram_rdata;

  logic             div_start;
  logic             div_done;
  logic [DVD_W-1:0] div_quot;

  assign accept   = in_i.valid && in_i.ready;
  assign ifc_idx  = IFC_W'(ifc_q);
  assign ram_addr = RAM_AW'({ifc_idx, slot_q[ifc_idx]});

  // one mean read port, shared by the primary and secondary lookups
  assign mean_sel = (state_q == ST_EVAL_P) ? pri_q : sec_q;
  assign mean_idx = IFC_W'(mean_sel);
  assign mean_ok  = (32'(mean_sel) < NUM_IFACES);
  assign mean_rd  = mean_ok ? mean_q[mean_idx] : '0;

  assign full    = (cnt_q[ifc_idx] == CNT_W'(WINDOW_LEN));
  assign new_sum = sum_q[ifc_idx] - (full ? SUM_W'(ram_rdata) : '0) + SUM_W'(lat_q);
  assign new_cnt = full ? cnt_q[ifc_idx] : cnt_q[ifc_idx] + 1'b1;
  assign thr_q8  = {thr_q, {FRAC_W{1'b0}}};

  always_comb begin
    if (!on_sec_q) begin
      go = (p_q > thr_q8) && ((CMP_W'(s_q) * CMP_W'(5)) < (CMP_W'(p_q) * CMP_W'(4)));
    end else begin
      go = (CMP_W'(p_q) * CMP_W'(10)) < (CMP_W'(thr_q8) * CMP_W'(7));
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    func_d     = func_q;
    ifc_d      = ifc_q;
    lat_d      = lat_q;
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    slot_d     = slot_q;
    mean_d     = mean_q;
    on_sec_d   = on_sec_q;
    sw_total_d = sw_total_q;
    p_d        = p_q;
    s_d        = s_q;
    res_mean_d = res_mean_q;
    res_sw_d   = res_sw_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    div_start  = 1'b0;
    res_load   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          func_d     = in_i.func;
          ifc_d      = in_i.iface;
          lat_d      = in_i.latency_ms;
          res_mean_d = '0;
          res_sw_d   = 1'b0;
          if (in_i.func == FUNC_TICK) begin
            state_d = ST_EVAL_P;
          end else if (32'(in_i.iface) < NUM_IFACES) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        ram_we           = 1'b1;
        sum_d[ifc_idx]   = new_sum;
        cnt_d[ifc_idx]   = new_cnt;
        slot_d[ifc_idx]  = (slot_q[ifc_idx] == POS_W'(WINDOW_LEN - 1)) ? '0
                         : slot_q[ifc_idx] + 1'b1;
        div_start        = 1'b1;
        state_d          = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          mean_d[ifc_idx] = div_quot[MEAN_W-1:0];
          res_mean_d      = div_quot[MEAN_W-1:0];
          state_d         = ST_DONE;
        end
      end
      ST_EVAL_P: begin
        p_d     = mean_rd;
        state_d = ST_EVAL_S;
      end
      ST_EVAL_S: begin
        s_d     = mean_rd;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        res_sw_d = go;
        if (go) begin
          on_sec_d = !on_sec_q;
          if (sw_total_q != '1) begin
            sw_total_d = sw_total_q + 1'b1;
          end
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_path_d  = out_path_q;
    out_sw_d    = out_sw_q;
    out_cnt_d   = out_cnt_q;
    out_mean_d  = out_mean_q;
    if (res_load) begin
      out_valid_d = 1'b1;
      out_path_d  = on_sec_q ? sec_q : pri_q;
      out_sw_d    = res_sw_q;
      out_cnt_d   = sw_total_q;
      out_mean_d  = res_mean_q;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // configuration writes
  always_comb begin
    thr_d = thr_q;
    pri_d = pri_q;
    sec_d = sec_q;
    if (cfg_we_i) begin
      unique case (wlpf_cfg_e'(cfg_idx_i))
        CFG_THRESHOLD: thr_d = cfg_wdata_i[LAT_W-1:0];
        CFG_PRIMARY:   pri_d = cfg_wdata_i[IFACE_W-1:0];
        CFG_SECONDARY: sec_d = cfg_wdata_i[IFACE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      on_sec_q    <= 1'b0;
      sw_total_q  <= '0;
      thr_q       <= THRESHOLD_RST;
      pri_q       <= PRIMARY_RST;
      sec_q       <= SECONDARY_RST;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_IFACES; i++) begin
        sum_q[i]  <= '0;
        cnt_q[i]  <= '0;
        slot_q[i] <= '0;
        mean_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      on_sec_q    <= on_sec_d;
      sw_total_q  <= sw_total_d;
      thr_q       <= thr_d;
      pri_q       <= pri_d;
      sec_q       <= sec_d;
      out_valid_q <= out_valid_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      slot_q      <= slot_d;
      mean_q      <= mean_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    ifc_q      <= ifc_d;
    lat_q      <= lat_d;
    p_q        <= p_d;
    s_q        <= s_d;
    res_mean_q <= res_mean_d;
    res_sw_q   <= res_sw_d;
    out_path_q <= out_path_d;
    out_sw_q   <= out_sw_d;
    out_cnt_q  <= out_cnt_d;
    out_mean_q <= out_mean_d;
  end

  wlpf_ram #(
    .WIDTH (LAT_W),
    .DEPTH (RAM_DEP)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (lat_q),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  wlpf_div #(
    .DVD_W (DVD_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({new_sum, {FRAC_W{1'b0}}}),
    .divisor_i  (new_cnt),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign in_i.ready            = (state_q == ST_IDLE);
  assign out_o.valid           = out_valid_q;
  assign out_o.current_path    = out_path_q;
  assign out_o.switched        = out_sw_q;
  assign out_o.switch_count    = out_cnt_q;
  assign out_o.mean_latency_q8 = out_mean_q;

  `WLPF_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != ST_IDLE)
  `WLPF_ASSERT_NEXT(a_div_start_not_done, div_start, !div_done)
  `WLPF_ASSERT_NEXT(a_sample_never_switches, res_load && func_q == FUNC_SAMPLE, !out_o.switched)
  `WLPF_ASSERT_NOW(a_count_bounded, state_q == ST_UPDATE, 32'(cnt_q[ifc_idx]) <= WINDOW_LEN)

endmodule

// ----- dv/windowed_latency_path_failover_test.sv -----
// self-checking testbench for the windowed latency path failover block
// drives sample and tick transactions with bursty traffic and a stalling receiver,
// predicts every result in a local window/failover model; needs wlpf_pkg and wlpf_if
module windowed_latency_path_failover_test;
  import wlpf_pkg::*;

  localparam int unsigned NUM_IF      = NUM_IFACES_DEF;
  localparam int unsigned WIN_LEN     = WINDOW_LEN_DEF;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_AT     = 300;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned DRAIN_WAIT  = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

  typedef enum logic [1:0] {
    SINK_FREE,
    SINK_COIN,
    SINK_SLOW
  } sink_mode_e;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [IFACE_W-1:0] iface;
    logic [LAT_W-1:0]   latency_ms;
  } lat_item_t;

  typedef struct packed {
    logic [IFACE_W-1:0] current_path;
    logic               switched;
    logic [SWCNT_W-1:0] switch_count;
    logic [MEAN_W-1:0]  mean_latency_q8;
  } path_status_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  wlpf_in_if  item_ch ();
  wlpf_out_if status_ch ();

  windowed_latency_path_failover dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (item_ch),
    .out_o       (status_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // window and failover model
  logic [LAT_W-1:0]   lat_ring [NUM_IF][WIN_LEN];
  logic [31:0]        win_sum  [NUM_IF];
  int unsigned        win_cnt  [NUM_IF];
  int unsigned        win_pos  [NUM_IF];
  logic [MEAN_W-1:0]  win_mean [NUM_IF];
  bit                 on_backup;
  logic [SWCNT_W-1:0] switches;

  logic [LAT_W-1:0]   thr_r;
  logic [IFACE_W-1:0] prim_r;
  logic [IFACE_W-1:0] sec_r;

  lat_item_t    latency_item_q [$];
  path_status_t pending_status_q [$];
  int unsigned  items_queued;
  int unsigned  statuses_seen;
  int unsigned  fail_cnt;
  int unsigned  cycle_cnt;

  function automatic path_status_t apply_latency_item(lat_item_t it);
    path_status_t st;
    logic [63:0]  p;
    logic [63:0]  s;
    logic [63:0]  t;
    bit           go;
    int unsigned  k;
    st.switched        = 1'b0;
    st.mean_latency_q8 = '0;
    if (it.func == FUNC_SAMPLE) begin
      k = it.iface;
      if (win_cnt[k] >= WIN_LEN) begin
        win_sum[k] -= 32'(lat_ring[k][win_pos[k]]);
      end else begin
        win_cnt[k]++;
      end
      lat_ring[k][win_pos[k]] = it.latency_ms;
      win_sum[k] += 32'(it.latency_ms);
      win_pos[k] = (win_pos[k] + 1 >= WIN_LEN) ? 0 : win_pos[k] + 1;
      win_mean[k] = MEAN_W'((64'(win_sum[k]) << FRAC_W) / 64'(win_cnt[k]));
      st.mean_latency_q8 = win_mean[k];
    end else begin
      p = 64'(win_mean[prim_r]);
      s = 64'(win_mean[sec_r]);
      t = 64'(thr_r) << FRAC_W;
      if (on_backup) go = (10 * p < 7 * t);
      else           go = (p > t) && (5 * s < 4 * p);
      if (go) begin
        on_backup = !on_backup;
        if (switches != '1) switches++;
      end
      st.switched = go;
    end
    st.current_path = on_backup ? sec_r : prim_r;
    st.switch_count = switches;
    return st;
  endfunction

  // sender: bursts of random length separated by random gaps
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin : feed
    lat_item_t acc;
    lat_item_t nxt;
    if (!rst_ni) begin
      item_ch.valid      <= 1'b0;
      item_ch.func       <= FUNC_SAMPLE;
      item_ch.iface      <= '0;
      item_ch.latency_ms <= '0;
      burst_left         <= 0;
      gap_left           <= 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        acc.func       = item_ch.func;
        acc.iface      = item_ch.iface;
        acc.latency_ms = item_ch.latency_ms;
        pending_status_q = {pending_status_q, apply_latency_item(acc)};
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          item_ch.valid <= 1'b0;
        end else if (latency_item_q.size() != 0) begin
          nxt = latency_item_q.pop_front();
          item_ch.valid      <= 1'b1;
          item_ch.func       <= nxt.func;
          item_ch.iface      <= nxt.iface;
          item_ch.latency_ms <= nxt.latency_ms;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 16);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
          end
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: changing stall pattern plus one long hold-off
  sink_mode_e  sink_mode;
  int unsigned mode_left;
  int unsigned hold_left;
  int unsigned sink_seen;
  bit          hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_ch.ready <= 1'b0;
      sink_mode       <= SINK_FREE;
      mode_left       <= 0;
      hold_left       <= 0;
      sink_seen       <= 0;
      hold_done       <= 1'b0;
    end else begin
      if (status_ch.valid && status_ch.ready) sink_seen <= sink_seen + 1;
      if (hold_left != 0) begin
        hold_left       <= hold_left - 1;
        status_ch.ready <= (hold_left == 1);
      end else if (!hold_done && sink_seen == HOLD_AT) begin
        hold_done       <= 1'b1;
        hold_left       <= HOLD_CYCLES;
        status_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          sink_mode <= sink_mode_e'($urandom_range(0, 2));
          mode_left <= $urandom_range(20, 300);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (sink_mode)
          SINK_FREE: status_ch.ready <= 1'b1;
          SINK_COIN: status_ch.ready <= 1'($urandom_range(0, 1));
          default:   status_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk_i or negedge rst_ni) begin : check
    path_status_t want;
    if (rst_ni && status_ch.valid && status_ch.ready) begin
      statuses_seen++;
      if (pending_status_q.size() == 0) begin
        $error("result transaction with nothing pending");
        fail_cnt++;
      end else begin
        want = pending_status_q.pop_front();
        if (status_ch.current_path !== want.current_path) begin
          $error("current_path mismatch: expected %0d, actual %0d",
                 want.current_path, status_ch.current_path);
          fail_cnt++;
        end
        if (status_ch.switched !== want.switched) begin
          $error("switched mismatch: expected %0d, actual %0d",
                 want.switched, status_ch.switched);
          fail_cnt++;
        end
        if (status_ch.switch_count !== want.switch_count) begin
          $error("switch_count mismatch: expected %0d, actual %0d",
                 want.switch_count, status_ch.switch_count);
          fail_cnt++;
        end
        if (status_ch.mean_latency_q8 !== want.mean_latency_q8) begin
          $error("mean_latency_q8 mismatch: expected %0d, actual %0d",
                 want.mean_latency_q8, status_ch.mean_latency_q8);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_item(logic [FUNC_W-1:0] func, int unsigned iface, int unsigned lat);
    lat_item_t it;
    it.func       = func;
    it.iface      = IFACE_W'(iface);
    it.latency_ms = LAT_W'(lat);
    latency_item_q = {latency_item_q, it};
    items_queued++;
  endtask

  task automatic settle();
    while (statuses_seen != items_queued) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_THRESHOLD: thr_r  = data;
      CFG_PRIMARY:   prim_r = data[IFACE_W-1:0];
      CFG_SECONDARY: sec_r  = data[IFACE_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] iface_word(int unsigned iface);
    return {(CFG_DATA_W - IFACE_W)'($urandom), IFACE_W'(iface)};
  endfunction

  function automatic int unsigned pick_level(int unsigned thr);
    int unsigned base;
    base = (thr < 16) ? 16 : thr;
    case ($urandom_range(0, 4))
      0:       return base / 4;
      1:       return base / 2;
      2:       return base;
      3:       return base * 2;
      default: return base * 3;
    endcase
  endfunction

  // well-formed traffic: per-interface latency levels that drift, frequent ticks
  task automatic run_phase(int unsigned thr, int unsigned prim, int unsigned sec, int n);
    int unsigned lvl [NUM_IF];
    int unsigned ifc;
    int unsigned lat;
    int unsigned r;
    settle();
    write_reg(CFG_THRESHOLD, LAT_W'(thr));
    write_reg(CFG_PRIMARY, iface_word(prim));
    write_reg(CFG_SECONDARY, iface_word(sec));
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    foreach (lvl[i]) lvl[i] = pick_level(thr);
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(0, 3) == 0) begin
        push_item(FUNC_TICK, $urandom_range(0, 7), $urandom_range(0, 65535));
      end else begin
        r = $urandom_range(0, 9);
        if (r < 4)      ifc = prim;
        else if (r < 7) ifc = sec;
        else            ifc = $urandom_range(0, NUM_IF - 1);
        if ($urandom_range(0, 59) == 0) lvl[ifc] = pick_level(thr);
        if ($urandom_range(0, 39) == 0) lat = $urandom_range(0, 65535);
        else lat = lvl[ifc] + $urandom_range(0, lvl[ifc] / 4 + 1);
        if (lat > 65535) lat = 65535;
        push_item(FUNC_SAMPLE, ifc, lat);
      end
    end
  endtask

  initial begin
    int unsigned p;
    rst_ni        <= 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_THRESHOLD;
    cfg_wdata_i   = '0;
    items_queued  = 0;
    statuses_seen = 0;
    fail_cnt      = 0;
    cycle_cnt     = 0;
    on_backup     = 1'b0;
    switches      = '0;
    thr_r         = THRESHOLD_RST;
    prim_r        = PRIMARY_RST;
    sec_r         = SECONDARY_RST;
    for (int i = 0; i < NUM_IF; i++) begin
      win_sum[i]  = '0;
      win_cnt[i]  = 0;
      win_pos[i]  = 0;
      win_mean[i] = '0;
      for (int j = 0; j < WIN_LEN; j++) lat_ring[i][j] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // unmeasured interfaces, full-scale primary forces a failover
    push_item(FUNC_TICK, 7, 65535);
    push_item(FUNC_SAMPLE, 1, 65535);
    push_item(FUNC_SAMPLE, 2, 0);
    push_item(FUNC_TICK, 0, 0);
    push_item(FUNC_TICK, 5, 12345);
    push_item(FUNC_SAMPLE, 1, 0);
    push_item(FUNC_SAMPLE, 0, 16'h5555);
    push_item(FUNC_SAMPLE, 7, 16'hAAAA);
    push_item(FUNC_SAMPLE, 3, 1);
    push_item(FUNC_SAMPLE, 4, 16'hFFFE);
    push_item(FUNC_SAMPLE, 5, 16'h8000);
    push_item(FUNC_SAMPLE, 6, 16'h7FFF);
    push_item(FUNC_TICK, 3, 16'hFFFF);
    settle();

    // path kept across register changes, then return to a quiet primary
    write_reg(CFG_PRIMARY, iface_word(2));
    write_reg(CFG_SPARE, 16'hFFFF);
    push_item(FUNC_TICK, 0, 0);
    settle();

    // zero threshold
    write_reg(CFG_THRESHOLD, '0);
    write_reg(CFG_PRIMARY, iface_word(7));
    write_reg(CFG_SECONDARY, iface_word(0));
    push_item(FUNC_TICK, 1, 1);
    push_item(FUNC_TICK, 2, 2);
    settle();

    // primary equal to secondary, maximum threshold
    write_reg(CFG_PRIMARY, iface_word(3));
    write_reg(CFG_SECONDARY, iface_word(3));
    push_item(FUNC_TICK, 0, 0);
    settle();
    write_reg(CFG_THRESHOLD, '1);
    push_item(FUNC_SAMPLE, 3, 65535);
    push_item(FUNC_TICK, 0, 0);
    push_item(FUNC_TICK, 0, 0);

    run_phase(30, 1, 2, 500);
    run_phase($urandom_range(10, 300), $urandom_range(0, 7), $urandom_range(0, 7), 350);
    run_phase(0, 0, 7, 150);
    run_phase(65535, 7, 0, 150);
    p = $urandom_range(0, 7);
    run_phase($urandom_range(10, 300), p, p, 200);
    run_phase($urandom_range(1, 2000), $urandom_range(0, 7), $urandom_range(0, 7), 350);

    settle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (pending_status_q.size() != 0)
      $error("%0d expected results never arrived", pending_status_q.size());
    if (fail_cnt == 0 && pending_status_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
